### rtl/sorted_event_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// Sorted event priority queue assertion macros
// Wrap the concurrent checks so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef SORTED_EVENT_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_EVENT_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define SEPQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sepq: assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define SEPQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sepq: assertion failed");
`else
`define SEPQ_ASSERT_IMP(label, ante, cons)
`define SEPQ_ASSERT_NXT(label, ante, cons)
`endif

`endif

### rtl/sepq_pkg.sv
// ----------------------------------------------------------------------------
// sepq_pkg
// Shared types and codes of the sorted event priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sepq_pkg;

    localparam int TIME_W      = 32;
    localparam int TAG_W       = 16;
    localparam int ENTRY_CNT_W = 7;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] event_time;
        logic [TAG_W-1:0]  event_tag;
    } in_item_t;

    typedef struct packed {
        logic                   out_valid;
        logic [TIME_W-1:0]      out_time;
        logic [TAG_W-1:0]       out_tag;
        logic [ENTRY_CNT_W-1:0] entry_count;
        logic                   queue_empty;
        logic                   overflow;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic [TAG_W-1:0]  ev_tag;
    } entry_t;

    typedef enum logic [1:0] {
        RD_TAIL,
        RD_HEAD,
        RD_DOWN,
        RD_UP
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_MOVE_UP,
        WR_MOVE_DN,
        WR_ITEM_NEXT,
        WR_ITEM_CUR
    } wr_sel_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_NULL,
        RES_OVF,
        RES_HEAD
    } res_sel_t;

    typedef struct packed {
        logic     load;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        logic     step_dn;
        logic     step_up;
        logic     cnt_inc;
        logic     cnt_dec;
        res_sel_t res_sel;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic action;
        logic count_zero;
        logic full;
        logic move;
        logic cur_zero;
        logic cur_last;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

### rtl/sepq_req_if.sv
// ----------------------------------------------------------------------------
// sepq_req_if
// Request channel: valid/ready handshake carrying one queue command.
// ----------------------------------------------------------------------------
`default_nettype none

interface sepq_req_if;
    logic               valid;
    logic               ready;
    sepq_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/sepq_rsp_if.sv
// ----------------------------------------------------------------------------
// sepq_rsp_if
// Response channel: valid/ready handshake carrying one queue result.
// ----------------------------------------------------------------------------
`default_nettype none

interface sepq_rsp_if;
    logic                valid;
    logic                ready;
    sepq_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/sepq_ctrl.sv
// ----------------------------------------------------------------------------
// sepq_ctrl
// Sequencer for insert and remove: drives datapath commands one step a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sepq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  sepq_pkg::dp_sts_t      sts,
    output sepq_pkg::dp_cmd_t      cmd
);
    import sepq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PUT,
        S_REM_SHIFT,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_sel   = RD_HEAD;
        cmd.wr_sel   = WR_NONE;
        cmd.res_sel  = RES_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.action == ACT_INSERT)
                    begin
                        if (sts.full)
                        begin
                            cmd.res_sel = RES_OVF;
                            state_next  = S_EMIT;
                        end
                        else if (sts.count_zero)
                        begin
                            state_next = S_INS_PUT;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_TAIL;
                            state_next = S_INS_SCAN;
                        end
                    end
                    else
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.res_sel = RES_NULL;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_HEAD;
                            state_next = S_REM_SHIFT;
                        end
                    end
                end
            end
            S_INS_SCAN:
            begin
                if (sts.move)
                begin
                    cmd.wr_sel = WR_MOVE_UP;
                    if (sts.cur_zero)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        cmd.step_dn = 1'b1;
                        cmd.rd_sel  = RD_DOWN;
                    end
                end
                else
                begin
                    cmd.wr_sel  = WR_ITEM_NEXT;
                    cmd.cnt_inc = 1'b1;
                    cmd.res_sel = RES_NULL;
                    state_next  = S_EMIT;
                end
            end
            S_INS_PUT:
            begin
                cmd.wr_sel  = WR_ITEM_CUR;
                cmd.cnt_inc = 1'b1;
                cmd.res_sel = RES_NULL;
                state_next  = S_EMIT;
            end
            S_REM_SHIFT:
            begin
                // capture the head, then pull each later entry one slot down
                if (sts.cur_zero)
                begin
                    cmd.res_sel = RES_HEAD;
                end
                else
                begin
                    cmd.wr_sel = WR_MOVE_DN;
                end
                if (sts.cur_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.step_up = 1'b1;
                    cmd.rd_sel  = RD_UP;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/sepq_dpath.sv
// ----------------------------------------------------------------------------
// sepq_dpath
// Entry memory, cursor, count, result staging and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_event_priority_queue_macros.svh"

module sepq_dpath #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  sepq_pkg::in_item_t     item,
    input  sepq_pkg::dp_cmd_t      cmd,
    output sepq_pkg::dp_sts_t      sts,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output sepq_pkg::out_item_t    out_data
);
    import sepq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    entry_t            mem [QUEUE_DEPTH];
    entry_t            rdata_reg;
    entry_t            item_reg;
    entry_t            wr_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     cursor_reg, cursor_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     count_m1;

    logic              res_valid_reg;
    logic [TIME_W-1:0] res_time_reg;
    logic [TAG_W-1:0]  res_tag_reg;
    logic              res_ovf_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    assign count_m1 = count_reg - CW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_TAIL: rd_addr = count_m1[AW-1:0];
            RD_HEAD: rd_addr = '0;
            RD_DOWN: rd_addr = cursor_reg - AW'(1);
            RD_UP:   rd_addr = cursor_reg + AW'(1);
            default: rd_addr = '0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cursor_reg;
        wr_data = rdata_reg;
        case (cmd.wr_sel)
            WR_MOVE_UP:
            begin
                wr_en   = 1'b1;
                wr_addr = cursor_reg + AW'(1);
            end
            WR_MOVE_DN:
            begin
                wr_en   = 1'b1;
                wr_addr = cursor_reg - AW'(1);
            end
            WR_ITEM_NEXT:
            begin
                wr_en   = 1'b1;
                wr_addr = cursor_reg + AW'(1);
                wr_data = item_reg;
            end
            WR_ITEM_CUR:
            begin
                wr_en   = 1'b1;
                wr_data = item_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // entry store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        if (cmd.load)
        begin
            if (item.action == ACT_INSERT && count_reg != '0)
            begin
                cursor_next = count_m1[AW-1:0];
            end
            else
            begin
                cursor_next = '0;
            end
        end
        else if (cmd.step_dn)
        begin
            cursor_next = cursor_reg - AW'(1);
        end
        else if (cmd.step_up)
        begin
            cursor_next = cursor_reg + AW'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg.ev_time <= item.event_time;
            item_reg.ev_tag  <= item.event_tag;
        end
        case (cmd.res_sel)
            RES_NULL:
            begin
                res_valid_reg <= 1'b0;
                res_time_reg  <= '0;
                res_tag_reg   <= '0;
                res_ovf_reg   <= 1'b0;
            end
            RES_OVF:
            begin
                res_valid_reg <= 1'b0;
                res_time_reg  <= '0;
                res_tag_reg   <= '0;
                res_ovf_reg   <= 1'b1;
            end
            RES_HEAD:
            begin
                res_valid_reg <= 1'b1;
                res_time_reg  <= rdata_reg.ev_time;
                res_tag_reg   <= rdata_reg.ev_tag;
                res_ovf_reg   <= 1'b0;
            end
            default:
            begin
                res_valid_reg <= res_valid_reg;
            end
        endcase
        if (cmd.out_load)
        begin
            out_data_reg.out_valid   <= res_valid_reg;
            out_data_reg.out_time    <= res_time_reg;
            out_data_reg.out_tag     <= res_tag_reg;
            out_data_reg.entry_count <= ENTRY_CNT_W'(count_reg);
            out_data_reg.queue_empty <= (count_reg == '0);
            out_data_reg.overflow    <= res_ovf_reg;
        end
    end

    always_comb
    begin
        sts.action     = item.action;
        sts.count_zero = (count_reg == '0);
        sts.full       = (count_reg == CW'(QUEUE_DEPTH));
        sts.cur_zero   = (cursor_reg == '0);
        sts.cur_last   = (CW'(cursor_reg) == count_m1);
        // at the head, an equal time stays behind it; elsewhere equal times move up
        sts.move       = sts.cur_zero ? (item_reg.ev_time < rdata_reg.ev_time)
                                      : (rdata_reg.ev_time >= item_reg.ev_time);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SEPQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `SEPQ_ASSERT_IMP(a_no_insert_full, cmd.cnt_inc, count_reg != CW'(QUEUE_DEPTH))
    `SEPQ_ASSERT_IMP(a_no_remove_empty, cmd.cnt_dec, count_reg != '0)
    `SEPQ_ASSERT_NXT(a_out_loaded, cmd.out_load, out_valid_reg)

endmodule

`default_nettype wire

### rtl/sorted_event_priority_queue.sv
// Insert: the sequencer moves each later entry up one slot from the tail, then writes the
// new event; an empty queue skips the scan and a full one goes straight to the overflow result.
// Remove: the sequencer steps through every held entry; an empty queue gives a null result.
// One item at a time; the entry memory moves one entry per cycle.
// The next item is taken the cycle after a result enters the output register.
// Reset: count and handshake state clear at once; entry memory is not cleared (no sweep).
// ----------------------------------------------------------------------------
// sorted_event_priority_queue
// Bounded event queue kept in ascending time order; pops the earliest event.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_event_priority_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sepq_req_if.sink     req,
    sepq_rsp_if.source   rsp
);
    import sepq_pkg::*;

    // Controller and datapath talk only through the command and status structs.
    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    in_ready;

    // Accept a beat only while the sequencer idles.
    assign req.ready = in_ready;

    sepq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: entries live in a memory sorted by time. An insert walks
    // from the tail toward the head, moving each later entry up one slot,
    // then drops the new event into the gap. A remove reads the head and
    // pulls every following entry down one slot. The output register holds
    // a finished beat until the sink takes it, so work on the next item is
    // not blocked by a stalled response.
    sepq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (req.data),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .out_data  (rsp.data)
    );

endmodule

`default_nettype wire

### test/tb_sorted_event_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_event_priority_queue
// Drives insert and remove commands with random gaps and random response
// stalls. A shadow queue predicts each result, and every response beat is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb_sorted_event_priority_queue;

    import sepq_pkg::*;

    localparam int QUEUE_DEPTH   = 64;
    localparam int RANDOM_BEATS  = 950;
    localparam int WATCHDOG_MAX  = 1000;
    localparam int DRAIN_CYCLES  = 100;

    // one command waiting to be driven, with the idle cycles that go before it
    typedef struct {
        in_item_t    cmd;
        int unsigned gap;
    } pending_cmd_t;

    logic clk;
    logic rst_n;

    sepq_req_if req_ch ();
    sepq_rsp_if rsp_ch ();

    sorted_event_priority_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the event queue, ascending by time
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] shadow_times [QUEUE_DEPTH];
    logic [TAG_W-1:0]  shadow_tags  [QUEUE_DEPTH];
    int unsigned       shadow_count;

    pending_cmd_t pending_cmds [$];
    out_item_t    expected_results [$];

    int unsigned fail_count;
    int unsigned inserts_sent;
    int unsigned removes_sent;
    int unsigned events_popped;
    int unsigned empty_removes;
    int unsigned dropped_inserts;
    int unsigned peak_count;
    int unsigned results_seen;

    // Apply one command to the shadow queue and return the result it must yield.
    function automatic out_item_t predict_queue_result(in_item_t cmd);
        out_item_t   res;
        int unsigned slot;
        res = '0;
        if (cmd.action == ACT_INSERT) begin
            inserts_sent++;
            if (shadow_count >= QUEUE_DEPTH) begin
                // full: drop the event, leave the store as it is
                res.overflow = 1'b1;
                dropped_inserts++;
            end
            else begin
                slot = 0;
                // an event not earlier than the head goes after all strictly
                // earlier events, but never ahead of the head itself
                if (shadow_count != 0 && cmd.event_time >= shadow_times[0]) begin
                    for (int i = 0; i < shadow_count; i++)
                        if (shadow_times[i] < cmd.event_time)
                            slot++;
                    if (slot == 0)
                        slot = 1;
                end
                for (int i = shadow_count; i > slot; i--) begin
                    shadow_times[i] = shadow_times[i-1];
                    shadow_tags[i]  = shadow_tags[i-1];
                end
                shadow_times[slot] = cmd.event_time;
                shadow_tags[slot]  = cmd.event_tag;
                shadow_count++;
                if (shadow_count > peak_count)
                    peak_count = shadow_count;
            end
        end
        else begin
            removes_sent++;
            if (shadow_count == 0) begin
                // empty: nothing to return, state unchanged
                empty_removes++;
            end
            else begin
                res.out_valid = 1'b1;
                res.out_time  = shadow_times[0];
                res.out_tag   = shadow_tags[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_times[i-1] = shadow_times[i];
                    shadow_tags[i-1]  = shadow_tags[i];
                end
                shadow_count--;
                events_popped++;
            end
        end
        res.entry_count = ENTRY_CNT_W'(shadow_count);
        res.queue_empty = (shadow_count == 0);
        return res;
    endfunction

    // Compare one response beat against the oldest prediction.
    function automatic void check_result(out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0) begin
            $error("response beat with no command outstanding: %p", got);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.out_valid !== want.out_valid) begin
            $error("out_valid: expected %0d, got %0d", want.out_valid, got.out_valid);
            fail_count++;
        end
        if (got.out_time !== want.out_time) begin
            $error("out_time: expected %h, got %h", want.out_time, got.out_time);
            fail_count++;
        end
        if (got.out_tag !== want.out_tag) begin
            $error("out_tag: expected %h, got %h", want.out_tag, got.out_tag);
            fail_count++;
        end
        if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            fail_count++;
        end
        if (got.queue_empty !== want.queue_empty) begin
            $error("queue_empty: expected %0d, got %0d", want.queue_empty, got.queue_empty);
            fail_count++;
        end
        if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        // hold every block input at a known value from time zero
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Command driver: present the next pending command after its gap
    // ------------------------------------------------------------------
    logic        drv_valid_next;
    int unsigned drv_idle;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            drv_idle = 0;
        end
        else begin
            drv_valid_next = req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                // beat taken: predict its result now, in acceptance order
                expected_results.push_back(predict_queue_result(req_ch.data));
                drv_valid_next = 1'b0;
            end
            if (!drv_valid_next && pending_cmds.size() != 0) begin
                if (drv_idle < pending_cmds[0].gap) begin
                    drv_idle++;
                end
                else begin
                    req_ch.data <= pending_cmds.pop_front().cmd;
                    drv_valid_next = 1'b1;
                    drv_idle = 0;
                end
            end
            // single update of valid per edge, so a back-to-back beat stays high
            req_ch.valid <= drv_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: check each beat, then stall a random while
    // ------------------------------------------------------------------
    int unsigned mon_hold;
    int unsigned mon_run_left;
    bit          mon_calm;

    // Draw the stall after a beat; each run of beats is calm or busy, calm one run in four.
    function automatic int unsigned next_stall();
        if (mon_run_left == 0) begin
            mon_calm     = ($urandom_range(0, 3) == 0);
            mon_run_left = $urandom_range(5, 40);
        end
        mon_run_left--;
        return mon_calm ? 0 : $urandom_range(0, 9);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            mon_hold     = 0;
            mon_run_left = 0;
            mon_calm     = 1'b0;
        end
        else if (rsp_ch.valid && rsp_ch.ready) begin
            check_result(rsp_ch.data);
            results_seen++;
            mon_hold = next_stall();
            rsp_ch.ready <= (mon_hold == 0);
        end
        else if (!rsp_ch.ready) begin
            if (mon_hold != 0)
                mon_hold--;
            rsp_ch.ready <= (mon_hold == 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves a beat for too long
    // ------------------------------------------------------------------
    int unsigned quiet_cycles;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            quiet_cycles = 0;
        end
        else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
        end
        else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("timeout: no beat for %0d cycles, %0d results outstanding",
                         WATCHDOG_MAX, expected_results.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    bit src_calm;

    task automatic add_cmd(logic act, logic [TIME_W-1:0] t, logic [TAG_W-1:0] g);
        pending_cmd_t p;
        p.cmd.action     = act;
        p.cmd.event_time = t;
        p.cmd.event_tag  = g;
        p.gap            = src_calm ? 0 : $urandom_range(0, 9);
        pending_cmds.push_back(p);
    endtask

    // Times cluster on a few small and a few near-max values so that ties are common.
    function automatic logic [TIME_W-1:0] pick_time();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return TIME_W'($urandom_range(0, 15));
        else if (sel < 6)
            return 32'hFFFF_FFF0 + TIME_W'($urandom_range(0, 15));
        else if (sel == 6)
            return $urandom_range(0, 1) ? '1 : '0;
        else
            return $urandom();
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        else
            return TAG_W'($urandom_range(0, 65535));
    endfunction

    initial begin
        int unsigned made;
        int unsigned burst_len;
        int unsigned insert_pct;
        int unsigned pct_sel;

        src_calm = 1'b0;

        // directed opening: empty remove, ordering and tie rules, field extremes
        add_cmd(ACT_REMOVE, 32'h0000_0000, 16'h0000);
        add_cmd(ACT_INSERT, 32'd100,       16'h0001);
        add_cmd(ACT_INSERT, 32'd100,       16'h0002);   // ties the head: goes right behind it
        add_cmd(ACT_INSERT, 32'd50,        16'h0003);   // below the head: goes to the front
        add_cmd(ACT_INSERT, 32'd100,       16'h0004);   // ahead of the equal-time events
        add_cmd(ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        add_cmd(ACT_INSERT, 32'h0000_0000, 16'h0000);
        add_cmd(ACT_INSERT, 32'd200,       16'hA5A5);
        add_cmd(ACT_INSERT, 32'd0,         16'h5A5A);   // ties a new head of zero
        add_cmd(ACT_INSERT, 32'hFFFF_FFFF, 16'h1234);
        for (int i = 0; i < 11; i++)
            add_cmd(ACT_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);  // drains, last ones hit empty

        // random bursts, each with its own insert/remove mix and pacing
        made = 0;
        while (made < RANDOM_BEATS) begin
            pct_sel   = $urandom_range(0, 4);
            insert_pct = (pct_sel == 0) ? 10 :
                         (pct_sel == 1) ? 50 :
                         (pct_sel == 2) ? 65 :
                         (pct_sel == 3) ? 85 : 100;
            burst_len = $urandom_range(10, 80);
            src_calm  = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < burst_len && made < RANDOM_BEATS; i++) begin
                if ($urandom_range(1, 100) <= insert_pct)
                    add_cmd(ACT_INSERT, pick_time(), pick_tag());
                else
                    add_cmd(ACT_REMOVE, $urandom(), pick_tag());
                made++;
            end
        end

        // wait for every command to go out and every result to come back;
        // sample mid-cycle so that the edge updates have settled
        @(posedge rst_n);
        while (pending_cmds.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        // leave room for any stray extra result to show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d commands: %0d inserts (%0d dropped as full), %0d removes",
                 inserts_sent + removes_sent, inserts_sent, dropped_inserts, removes_sent);
        $display("popped %0d events, %0d removes on empty, peak fill %0d of %0d, %0d results",
                 events_popped, empty_removes, peak_count, QUEUE_DEPTH, results_seen);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/sepq_pkg.sv
rtl/sepq_req_if.sv
rtl/sepq_rsp_if.sv
rtl/sepq_ctrl.sv
rtl/sepq_dpath.sv
rtl/sorted_event_priority_queue.sv
test/tb_sorted_event_priority_queue.sv
